// ----- rtl/goal_seek_velocity_controller_core_assert.svh -----
// assertion macros used by the top level of the goal-seek velocity controller
`ifndef GOAL_SEEK_VELOCITY_CONTROLLER_CORE_ASSERT_SVH
`define GOAL_SEEK_VELOCITY_CONTROLLER_CORE_ASSERT_SVH

// same-cycle implication
`define GSVC_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gsvc check failed");

// next-cycle implication
`define GSVC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gsvc check failed");

`endif

// ----- rtl/gsvc_pkg.sv -----
// shared types and constants of the goal-seek velocity controller
`default_nettype none
package gsvc_pkg;
  localparam int POS_W    = 24;
  localparam int DIFF_W   = POS_W + 1;
  localparam int SQ_W     = 2 * DIFF_W;
  localparam int SPD_W    = 17;
  localparam int PROD_W   = DIFF_W + SPD_W;
  localparam int ROOT_W   = DIFF_W;
  localparam int VEL_W    = 18;
  localparam int MODE_W   = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [SPD_W-1:0] SPEED_MAX = 17'd65536;
  localparam logic [SPD_W-1:0] SPEED_RST = 17'd328;
  localparam logic [SPD_W-1:0] THR_RST   = 17'd1311;

  localparam logic [CFG_IDX_W-1:0] CFG_SPEED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THR   = 2'd1;

  localparam logic [MODE_W-1:0] MODE_INITIAL = 3'd0;
  localparam logic [MODE_W-1:0] MODE_READY   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MOVING  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_INVALID = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DONE    = 3'd4;

  typedef struct packed {
    logic load;
    logic mul;
    logic sum;
    logic div_start;
  } ctl_t;
endpackage
`default_nettype wire

// ----- rtl/gsvc_lane.sv -----
// one axis lane: difference, square, speed product and serial divider
`default_nettype none
module gsvc_lane import gsvc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  ctl_t                    ctl,
  input  logic signed [POS_W-1:0] cur,
  input  logic signed [POS_W-1:0] goal,
  input  logic [SPD_W-1:0]        spd,
  input  logic [ROOT_W-1:0]       len,
  output logic [SQ_W-1:0]         sq,
  output logic                    busy,
  output logic signed [VEL_W-1:0] vel
);
  localparam int CNT_W = $clog2(PROD_W + 1);

  logic signed [DIFF_W-1:0] d;
  logic              neg;
  logic [DIFF_W-1:0] mag;
  logic [PROD_W-1:0] prod;
  logic [ROOT_W-1:0] rem;
  logic [PROD_W-1:0] quo;
  logic [CNT_W-1:0]  cnt;
  logic [ROOT_W:0]   rem_sh;
  logic              ge;
  logic [ROOT_W:0]   rem_sub;
  logic [SPD_W-1:0]  q;

  assign d = {goal[POS_W-1], goal} - {cur[POS_W-1], cur};

  // restoring division step, one quotient bit a cycle
  assign rem_sh  = {rem, quo[PROD_W-1]};
  assign ge      = rem_sh >= {1'b0, len};
  assign rem_sub = rem_sh - {1'b0, len};

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      neg <= d[DIFF_W-1];
      mag <= d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    end
    if (ctl.mul) begin
      sq   <= mag * mag;
      prod <= mag * spd;
    end
    if (ctl.div_start) begin
      rem <= '0;
      quo <= prod;
    end else if (busy) begin
      rem <= ge ? rem_sub[ROOT_W-1:0] : rem_sh[ROOT_W-1:0];
      quo <= {quo[PROD_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (ctl.div_start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(PROD_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // |d| <= len keeps the quotient within speed; the clamp only guards
  always_comb begin
    if (len == '0) begin
      q = '0;
    end else if (quo > PROD_W'(SPEED_MAX)) begin
      q = SPEED_MAX;
    end else begin
      q = quo[SPD_W-1:0];
    end
    vel = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
  end
endmodule
`default_nettype wire

// ----- rtl/gsvc_sqrt.sv -----
// bit-serial integer square root, two radicand bits a cycle
`default_nettype none
module gsvc_sqrt import gsvc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SQ_W-1:0]   value,
  output logic              busy,
  output logic [ROOT_W-1:0] root
);
  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic [SQ_W-1:0]   n;
  logic [ROOT_W:0]   rem;
  logic [CNT_W-1:0]  cnt;
  logic [ROOT_W+2:0] rem_sh;
  logic [ROOT_W+2:0] trial;
  logic              ge;
  logic [ROOT_W+2:0] rem_sub;

  assign rem_sh  = {rem, n[SQ_W-1:SQ_W-2]};
  assign trial   = {1'b0, root, 2'b01};
  assign ge      = rem_sh >= trial;
  assign rem_sub = rem_sh - trial;

  always_ff @(posedge clk) begin
    if (start) begin
      n    <= value;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      n    <= {n[SQ_W-3:0], 2'b00};
      rem  <= ge ? rem_sub[ROOT_W:0] : rem_sh[ROOT_W:0];
      root <= {root[ROOT_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(ROOT_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// ----- rtl/gsvc_merge.sv -----
// merges lane squares into the distance sum and the arrival test
`default_nettype none
module gsvc_merge import gsvc_pkg::*; (
  input  logic              clk,
  input  ctl_t              ctl,
  input  logic [SPD_W-1:0]  thr,
  input  logic [SQ_W-1:0]   sq_x,
  input  logic [SQ_W-1:0]   sq_y,
  input  logic [SQ_W-1:0]   sq_z,
  output logic [SQ_W-1:0]   sum,
  output logic              arrive
);
  logic [2*SPD_W-1:0] thr2;
  logic [SQ_W-1:0]    sum_c;

  // each square is at most 2^48, so three of them fit
  assign sum_c = sq_x + sq_y + sq_z;

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      thr2 <= thr * thr;
    end
    if (ctl.sum) begin
      sum    <= sum_c;
      arrive <= sum_c < SQ_W'(thr2);
    end
  end
endmodule
`default_nettype wire

// ----- rtl/goal_seek_velocity_controller_core.sv -----
// top level of the goal-seek velocity controller
//
//  channel   dir  handshake                   payload
//  s_axis    in   s_axis_tvalid/tready        tdata positions, tuser command
//  m_axis    out  m_axis_tvalid/tready        tdata velocity and modes
//  cfg       in   cfg_valid/cfg_ready         cfg_index, cfg_data
//
// from the accept to the output register load, in order:
// a set command or a step in a holding mode needs only the accept and the load
// a step that arrives passes the multiply, sum and check setup states, then the load
// any other step passes the setup states, the serial square root and its hand-off,
// the three lane dividers running side by side, and the load
// one item at a time; the next item is taken while the result waits in the output register
// a stalled output holds the finished result and keeps s_axis_tready low
// reset is synchronous; modes return to initial and registers to their defaults
`default_nettype none
`include "goal_seek_velocity_controller_core_assert.svh"
module goal_seek_velocity_controller_core import gsvc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // current_x, current_y, current_z, goal_x, goal_y, goal_z
  input  logic [6*POS_W-1:0]   s_axis_tdata,
  // command, new_mode
  input  logic [MODE_W:0]      s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // vel_x, vel_y, vel_z, mode_now, mode_before, zero pad
  output logic [63:0]          m_axis_tdata,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SPD_W-1:0]     cfg_data
);
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_SUM  = 6'b000100,
    S_CHK  = 6'b001000,
    S_ROOT = 6'b010000,
    S_DIV  = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   fin;

  logic [SPD_W-1:0]  speed;
  logic [SPD_W-1:0]  arrive_threshold;
  logic [SPD_W-1:0]  spd;
  logic [MODE_W-1:0] current_mode;
  logic [MODE_W-1:0] previous_mode;
  logic [MODE_W-1:0] target_mode;
  logic              zero_vel;

  logic in_accept, out_load, is_step, sqrt_start, sqrt_busy;
  logic [2:0] lane_busy;
  ctl_t ctl;

  logic signed [POS_W-1:0] cur  [3];
  logic signed [POS_W-1:0] goal [3];
  logic [SQ_W-1:0]         sq   [3];
  logic signed [VEL_W-1:0] vel  [3];
  logic [ROOT_W-1:0]       root;
  logic [SQ_W-1:0]         sum;
  logic                    arrive;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE) && !fin;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_load      = fin && (!m_axis_tvalid || m_axis_tready);
  assign is_step       = !s_axis_tuser[0] &&
                         (current_mode == MODE_READY || current_mode == MODE_MOVING);
  assign spd           = (speed > SPEED_MAX) ? SPEED_MAX : speed;

  always_comb begin
    ctl.load      = in_accept;
    ctl.mul       = state == S_MUL;
    ctl.sum       = state == S_SUM;
    ctl.div_start = (state == S_ROOT) && !sqrt_busy;
  end
  assign sqrt_start = (state == S_CHK) && !arrive;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed            <= SPEED_RST;
      arrive_threshold <= THR_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SPEED: speed            <= cfg_data;
        CFG_THR:   arrive_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_accept && is_step) state_next = S_MUL;
      S_MUL:  state_next = S_SUM;
      S_SUM:  state_next = S_CHK;
      S_CHK:  state_next = arrive ? S_IDLE : S_ROOT;
      S_ROOT: if (!sqrt_busy) state_next = S_DIV;
      S_DIV:  if (lane_busy == '0) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      fin           <= 1'b0;
      current_mode  <= MODE_INITIAL;
      previous_mode <= MODE_INITIAL;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      // fin marks a result ready for the output register
      if (in_accept && !is_step) begin
        fin <= 1'b1;
      end else if ((state == S_CHK) && arrive) begin
        fin <= 1'b1;
      end else if ((state == S_DIV) && (lane_busy == '0)) begin
        fin <= 1'b1;
      end else if (out_load) begin
        fin <= 1'b0;
      end
      if (out_load) begin
        current_mode  <= target_mode;
        previous_mode <= current_mode;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      target_mode <= s_axis_tuser[0] ? s_axis_tuser[MODE_W:1] : current_mode;
      zero_vel    <= 1'b1;
    end else if (state == S_CHK) begin
      target_mode <= arrive ? MODE_DONE : MODE_MOVING;
      zero_vel    <= arrive;
    end
    if (out_load) begin
      m_axis_tdata <= {4'b0000, current_mode, target_mode,
                       zero_vel ? VEL_W'(0) : vel[2],
                       zero_vel ? VEL_W'(0) : vel[1],
                       zero_vel ? VEL_W'(0) : vel[0]};
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    assign cur[i]  = s_axis_tdata[i*POS_W +: POS_W];
    assign goal[i] = s_axis_tdata[(i+3)*POS_W +: POS_W];
    gsvc_lane u_lane (
      .clk  (clk),
      .rst  (rst),
      .ctl  (ctl),
      .cur  (cur[i]),
      .goal (goal[i]),
      .spd  (spd),
      .len  (root),
      .sq   (sq[i]),
      .busy (lane_busy[i]),
      .vel  (vel[i])
    );
  end

  gsvc_merge u_merge (
    .clk    (clk),
    .ctl    (ctl),
    .thr    (arrive_threshold),
    .sq_x   (sq[0]),
    .sq_y   (sq[1]),
    .sq_z   (sq[2]),
    .sum    (sum),
    .arrive (arrive)
  );

  gsvc_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .value (sum),
    .busy  (sqrt_busy),
    .root  (root)
  );

  `GSVC_ASSERT_IMPL(a_div_after_root, clk, rst, state == S_ROOT, lane_busy == 3'b000)
  `GSVC_ASSERT_IMPL(a_idle_quiet, clk, rst, s_axis_tready, !sqrt_busy && lane_busy == 3'b000)
  `GSVC_ASSERT_NEXT(a_mode_before, clk, rst, out_load,
                    m_axis_tvalid && m_axis_tdata[59:57] == $past(current_mode))
endmodule
`default_nettype wire

// ----- tb/sv/goal_seek_velocity_controller_core_test.sv -----
// self-checking testbench of the goal-seek velocity controller core
`timescale 1ns / 1ps
module goal_seek_velocity_controller_core_test;
  import gsvc_pkg::*;

  typedef struct {
    logic [VEL_W-1:0]  vel_x;
    logic [VEL_W-1:0]  vel_y;
    logic [VEL_W-1:0]  vel_z;
    logic [MODE_W-1:0] mode_now;
    logic [MODE_W-1:0] mode_before;
  } velocity_t;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [6*POS_W-1:0] s_axis_tdata = '0;
  logic [MODE_W:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SPD_W-1:0] cfg_data = '0;

  goal_seek_velocity_controller_core i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // items waiting to be sent: {tuser, tdata}
  logic [MODE_W+6*POS_W:0] pending_items[$];
  velocity_t expected_velocities[$];
  int errors = 0;
  bit quiet = 1'b0;

  // predictor state
  logic [SPD_W-1:0] model_speed = SPEED_RST;
  logic [SPD_W-1:0] model_thr = THR_RST;
  logic [MODE_W-1:0] model_mode = MODE_INITIAL;
  logic [MODE_W-1:0] model_prev = MODE_INITIAL;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned floor_root(input longint unsigned n);
    longint unsigned root, probe;
    root = 0;
    probe = 64'd1 << 62;
    while (probe > n) probe >>= 2;
    while (probe != 0) begin
      if (n >= root + probe) begin
        n -= root + probe;
        root = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  function automatic logic [VEL_W-1:0] lane_velocity(input longint d, input longint unsigned spd,
                                                     input longint unsigned len);
    longint unsigned mag, q;
    if (len == 0) return '0;
    mag = (d < 0) ? longint'(-d) : longint'(d);
    q = (mag * spd) / len;
    if (q > SPEED_MAX) q = SPEED_MAX;
    if (d < 0) q = -q;
    return q[VEL_W-1:0];
  endfunction

  function automatic velocity_t advance_controller(input logic [MODE_W:0] user,
                                                   input logic [6*POS_W-1:0] pos);
    velocity_t r;
    longint dd[3];
    longint g, c;
    longint unsigned sq, len, spd, thr;
    logic [MODE_W-1:0] nxt;
    r.vel_x = '0;
    r.vel_y = '0;
    r.vel_z = '0;
    nxt = model_mode;
    if (user[0]) begin
      nxt = user[MODE_W:1];
    end else if (model_mode == MODE_READY || model_mode == MODE_MOVING) begin
      sq = 0;
      for (int i = 0; i < 3; i++) begin
        g = $signed(pos[POS_W*(i+3) +: POS_W]);
        c = $signed(pos[POS_W*i +: POS_W]);
        dd[i] = g - c;
        sq += dd[i] * dd[i];
      end
      thr = model_thr;
      if (sq < thr * thr) begin
        nxt = MODE_DONE;
      end else begin
        len = floor_root(sq);
        spd = (model_speed > SPEED_MAX) ? SPEED_MAX : model_speed;
        nxt = MODE_MOVING;
        r.vel_x = lane_velocity(dd[0], spd, len);
        r.vel_y = lane_velocity(dd[1], spd, len);
        r.vel_z = lane_velocity(dd[2], spd, len);
      end
    end
    model_prev = model_mode;
    model_mode = nxt;
    r.mode_now = model_mode;
    r.mode_before = model_prev;
    return r;
  endfunction

  // sender
  int s_gap = 0;
  always @(posedge clk) begin
    logic nxt_valid;
    logic [MODE_W+6*POS_W:0] it;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      nxt_valid = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_velocities.push_back(advance_controller(s_axis_tuser, s_axis_tdata));
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (s_gap > 0) begin
          s_gap--;
        end else if (pending_items.size() > 0) begin
          it = pending_items.pop_front();
          s_axis_tuser <= it[MODE_W+6*POS_W:6*POS_W];
          s_axis_tdata <= it[6*POS_W-1:0];
          nxt_valid = 1'b1;
          if (!quiet && $urandom_range(0, 7) == 0) s_gap = $urandom_range(1, 13);
        end
      end
      s_axis_tvalid <= nxt_valid;
    end
  end

  // receiver and checker
  int m_gap = 0;
  always @(posedge clk) begin
    velocity_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_velocities.size() == 0) begin
          $error("result item with nothing expected");
          errors++;
        end else begin
          want = expected_velocities.pop_front();
          if (m_axis_tdata[17:0] !== want.vel_x) begin
            $error("vel_x expected %0h actual %0h", want.vel_x, m_axis_tdata[17:0]);
            errors++;
          end
          if (m_axis_tdata[35:18] !== want.vel_y) begin
            $error("vel_y expected %0h actual %0h", want.vel_y, m_axis_tdata[35:18]);
            errors++;
          end
          if (m_axis_tdata[53:36] !== want.vel_z) begin
            $error("vel_z expected %0h actual %0h", want.vel_z, m_axis_tdata[53:36]);
            errors++;
          end
          if (m_axis_tdata[56:54] !== want.mode_now) begin
            $error("mode_now expected %0d actual %0d", want.mode_now, m_axis_tdata[56:54]);
            errors++;
          end
          if (m_axis_tdata[59:57] !== want.mode_before) begin
            $error("mode_before expected %0d actual %0d", want.mode_before,
                   m_axis_tdata[59:57]);
            errors++;
          end
        end
      end
      if (m_gap > 0) begin
        m_gap--;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        m_gap = $urandom_range(0, 12);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // register writes seen by the predictor
  always @(posedge clk) begin
    if (!rst && cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_SPEED) model_speed = cfg_data;
      else if (cfg_index == CFG_THR) model_thr = cfg_data;
    end
  end

  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("goal_seek_velocity_controller_core_test: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic add_item(input logic cmd, input logic [MODE_W-1:0] mode,
                          input logic [POS_W-1:0] cx, cy, cz, gx, gy, gz);
    pending_items.push_back({mode, cmd, gz, gy, gx, cz, cy, cx});
  endtask

  task automatic add_set(input logic [MODE_W-1:0] mode);
    add_item(1'b1, mode, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
             POS_W'($urandom), POS_W'($urandom), POS_W'($urandom));
  endtask

  function automatic logic [POS_W-1:0] offset(input logic [POS_W-1:0] p, input int kind);
    case (kind)
      0: return p;
      1, 2, 3: return p + POS_W'($urandom_range(0, 2046)) - POS_W'(1023);
      4, 5, 6: return p + POS_W'($urandom_range(0, 131070)) - POS_W'(65535);
      default: return POS_W'($urandom);
    endcase
  endfunction

  task automatic add_random_step();
    logic [POS_W-1:0] cx, cy, cz;
    int kind;
    cx = POS_W'($urandom);
    cy = POS_W'($urandom);
    cz = POS_W'($urandom);
    kind = $urandom_range(0, 9);
    add_item(1'b0, MODE_W'($urandom), cx, cy, cz,
             offset(cx, kind), offset(cy, kind), offset(cz, kind));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SPD_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || s_axis_tvalid || expected_velocities.size() > 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic add_directed();
    add_item(1'b0, MODE_READY, '0, '0, '0, 24'd1000, '0, '0);
    add_set(MODE_READY);
    add_item(1'b0, MODE_INITIAL, 24'h800000, 24'h800000, 24'h800000,
             24'h7fffff, 24'h7fffff, 24'h7fffff);
    add_item(1'b0, MODE_INITIAL, 24'h7fffff, 24'h000000, 24'h800000,
             24'h800000, 24'h000000, 24'h7fffff);
    add_item(1'b0, MODE_INITIAL, '0, '0, '0, 24'hfffff0, 24'd5, '0);
    add_item(1'b0, MODE_INITIAL, 24'd100, 24'd100, 24'd100, 24'd100, 24'd100, 24'd100);
    add_item(1'b0, MODE_INITIAL, '0, '0, '0, 24'd40000, '0, '0);
    add_set(MODE_MOVING);
    add_item(1'b0, MODE_INITIAL, '0, '0, '0, 24'd3000, 24'hfff000, 24'd1);
    add_item(1'b0, MODE_INITIAL, '0, '0, '0, 24'd500, '0, '0);
    add_set(MODE_INVALID);
    add_item(1'b0, MODE_MOVING, '0, '0, '0, 24'd70000, '0, '0);
    add_set(3'd5);
    add_item(1'b0, MODE_READY, '0, '0, '0, 24'd70000, '0, '0);
    add_set(3'd7);
    add_set(MODE_INITIAL);
    add_item(1'b0, MODE_READY, '0, '0, '0, 24'd70000, '0, '0);
    add_set(MODE_READY);
    add_item(1'b0, 3'd7, 24'h123456, 24'h654321, 24'habcdef,
             24'h123456, 24'h654321, 24'habcdef);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    add_directed();
    drain();
    write_reg(CFG_SPEED, SPEED_MAX);
    write_reg(CFG_THR, '0);
    add_directed();
    drain();
    write_reg(CFG_SPEED, 17'h1ffff);
    write_reg(CFG_THR, 17'h1ffff);
    add_directed();
    drain();
    write_reg(CFG_SPEED, '0);
    write_reg(CFG_THR, 17'd1);
    add_directed();
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_SPEED, SPD_W'($urandom_range(0, 131071)));
      write_reg(CFG_THR, (ph % 2) ? SPD_W'($urandom_range(0, 131071)) :
                                    SPD_W'($urandom_range(0, 4000)));
      if (ph == 5) quiet = 1'b1;
      for (int n = 0; n < 300; n++) begin
        int r;
        r = $urandom_range(0, 99);
        if (r < 6) add_set(MODE_W'($urandom_range(0, 7)));
        else if (r < 18) add_set(MODE_READY);
        else if (r < 22) add_set(MODE_MOVING);
        else add_random_step();
      end
      drain();
    end
    if (errors == 0) begin
      $display("goal_seek_velocity_controller_core_test: done, clean");
    end else begin
      $display("goal_seek_velocity_controller_core_test: done, errors");
    end
    $finish;
  end
endmodule

// ----- goal_seek_velocity_controller_core.f -----
+incdir+rtl
rtl/gsvc_pkg.sv
rtl/gsvc_lane.sv
rtl/gsvc_sqrt.sv
rtl/gsvc_merge.sv
rtl/goal_seek_velocity_controller_core.sv
tb/sv/goal_seek_velocity_controller_core_test.sv
